### design/assert_macros.svh
// Assertion macros for the RTL files of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### design/rbd_pkg.sv
// Types and constants of the ring buffer deque.
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = 5;
  localparam int DataW    = 32;
  localparam int PosW     = 5;
  localparam int ActW     = 3;
  localparam int StatW    = 2;
  // data_in/data_out plus position/count, padded to whole bytes
  localparam int TdataW   = 40;

  typedef enum logic [ActW-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_INSERT     = 3'd4,
    ACT_READ       = 3'd5,
    ACT_CLEAR      = 3'd6
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    status_e          status;
    logic [CntW-1:0]  count;
  } result_t;

endpackage

### design/ring_buffer_deque_core.sv
// Top level of the ring buffer deque: request sequencer, entry RAM and result register.
`timescale 1ns / 1ps
//  channel  | dir | tdata (low bit up)           | tuser
//  s_axis   | in  | data_in[31:0], position[4:0] | action[2:0]
//  m_axis   | out | data_out[31:0], count[4:0]   | status[1:0]
//
// One request at a time; states to result register load (S_RESP while it is occupied):
//   push, clear, rejected request, insert at front or at end: S_EXEC
//   pop and read: S_EXEC, then S_RDW for the registered RAM read data
//   mid insert: S_EXEC, S_SHIFT (count - position entries, one per cycle), S_INSW
// Reset clears state, head, count and output valid; the entry RAM is not cleared.
// A result waits in the output register while the next request is taken.
module ring_buffer_deque_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // data_in[31:0], position[36:32], zero pad
  input  logic [rbd_pkg::TdataW-1:0] s_axis_tdata_i,
  // action[2:0]
  input  logic [rbd_pkg::ActW-1:0]   s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // data_out[31:0], count[36:32], zero pad
  output logic [rbd_pkg::TdataW-1:0] m_axis_tdata_o,
  // status[1:0]
  output logic [rbd_pkg::StatW-1:0]  m_axis_tuser_o
);

  import rbd_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDW,
    S_SHIFT,
    S_INSW,
    S_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [ActW-1:0]  act_q, act_d;
  logic [DataW-1:0] val_q, val_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  idx_q, idx_d;
  result_t          res_q, res_d;
  result_t          out_q, out_d;
  logic             m_valid_q, m_valid_d;

  logic             s_fire;
  logic             out_free;
  logic             fin;
  result_t          res;
  logic             full, empty;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [DataW-1:0] wdata, rdata;

  logic [IdxW-1:0]  slot_front_m1, slot_cnt, slot_cnt_m1, slot_pos, slot_idx, slot_idx_m2;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign full            = (cnt_q == CntW'(Capacity));
  assign empty           = (cnt_q == '0);

  // physical slots, ring wrap by truncation
  assign slot_front_m1 = head_q - IdxW'(1);
  assign slot_cnt      = head_q + cnt_q[IdxW-1:0];
  assign slot_cnt_m1   = head_q + cnt_q[IdxW-1:0] - IdxW'(1);
  assign slot_pos      = head_q + pos_q[IdxW-1:0];
  assign slot_idx      = head_q + idx_q[IdxW-1:0];
  assign slot_idx_m2   = head_q + idx_q[IdxW-1:0] - IdxW'(2);

  // request sequencer
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    val_d      = val_q;
    pos_d      = pos_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    res_d      = res_q;
    out_d      = out_q;
    m_valid_d  = m_valid_q;
    we         = 1'b0;
    waddr      = head_q;
    wdata      = val_q;
    raddr      = head_q;
    fin        = 1'b0;
    res.data   = '0;
    res.status = ST_OK;
    res.count  = cnt_q;

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          act_d   = s_axis_tuser_i;
          val_d   = s_axis_tdata_i[DataW-1:0];
          pos_d   = s_axis_tdata_i[DataW+PosW-1:DataW];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_q)
          ACT_PUSH_FRONT: begin
            fin = 1'b1;
            if (full) begin
              res.status = ST_FULL;
            end else begin
              we     = 1'b1;
              waddr  = slot_front_m1;
              head_d = slot_front_m1;
              cnt_d  = cnt_q + CntW'(1);
            end
          end
          ACT_PUSH_BACK: begin
            fin = 1'b1;
            if (full) begin
              res.status = ST_FULL;
            end else begin
              we    = 1'b1;
              waddr = slot_cnt;
              cnt_d = cnt_q + CntW'(1);
            end
          end
          ACT_POP_FRONT: begin
            if (empty) begin
              fin        = 1'b1;
              res.status = ST_EMPTY;
            end else begin
              raddr   = head_q;
              head_d  = (cnt_q == CntW'(1)) ? '0 : head_q + IdxW'(1);
              cnt_d   = cnt_q - CntW'(1);
              state_d = S_RDW;
            end
          end
          ACT_POP_BACK: begin
            if (empty) begin
              fin        = 1'b1;
              res.status = ST_EMPTY;
            end else begin
              raddr   = slot_cnt_m1;
              head_d  = (cnt_q == CntW'(1)) ? '0 : head_q;
              cnt_d   = cnt_q - CntW'(1);
              state_d = S_RDW;
            end
          end
          ACT_INSERT: begin
            if (pos_q > cnt_q) begin
              fin        = 1'b1;
              res.status = ST_RANGE;
            end else if (full) begin
              fin        = 1'b1;
              res.status = ST_FULL;
            end else if (pos_q == '0) begin
              // same as push at front
              fin    = 1'b1;
              we     = 1'b1;
              waddr  = slot_front_m1;
              head_d = slot_front_m1;
              cnt_d  = cnt_q + CntW'(1);
            end else if (pos_q == cnt_q) begin
              // at the end: nothing to move
              fin   = 1'b1;
              we    = 1'b1;
              waddr = slot_pos;
              cnt_d = cnt_q + CntW'(1);
            end else begin
              // fetch last entry, then move entries up one by one
              raddr   = slot_cnt_m1;
              idx_d   = cnt_q;
              state_d = S_SHIFT;
            end
          end
          ACT_READ: begin
            if (pos_q >= cnt_q) begin
              fin        = 1'b1;
              res.status = ST_RANGE;
            end else begin
              raddr   = slot_pos;
              state_d = S_RDW;
            end
          end
          ACT_CLEAR: begin
            fin    = 1'b1;
            cnt_d  = '0;
            head_d = '0;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_RDW: begin
        fin      = 1'b1;
        res.data = rdata;
      end
      S_SHIFT: begin
        // write entry idx-1 into slot idx; read of idx-2 runs alongside
        we    = 1'b1;
        waddr = slot_idx;
        wdata = rdata;
        if ((idx_q - CntW'(1)) > pos_q) begin
          raddr = slot_idx_m2;
          idx_d = idx_q - CntW'(1);
        end else begin
          state_d = S_INSW;
        end
      end
      S_INSW: begin
        fin   = 1'b1;
        we    = 1'b1;
        waddr = slot_pos;
        cnt_d = cnt_q + CntW'(1);
      end
      S_RESP: begin
        if (out_free) begin
          out_d     = res_q;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hand the result to the output register, or park it
    if (fin) begin
      res.count = cnt_d;
      if (out_free) begin
        out_d     = res;
        m_valid_d = 1'b1;
        state_d   = S_IDLE;
      end else begin
        res_d   = res;
        state_d = S_RESP;
      end
    end
  end

  // control state, head, count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    val_q <= val_d;
    pos_q <= pos_d;
    idx_q <= idx_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // entry storage
  rbd_ram #(
    .Width(DataW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(TdataW - DataW - CntW){1'b0}}, out_q.count, out_q.data};
  assign m_axis_tuser_o  = out_q.status;

  // checks
  `ASSERT_SAME(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(Capacity),
               "entry count above capacity")
  `ASSERT_SAME(a_empty_head, clk_i, rst_ni, cnt_q == '0, head_q == '0,
               "head not at zero while empty")
  `ASSERT_SAME(a_shift_range, clk_i, rst_ni, state_q == S_SHIFT, idx_q > pos_q,
               "shift index at or below insert position")
  `ASSERT_NEXT(a_one_request, clk_i, rst_ni, s_fire, !s_axis_tready_o,
               "second request taken while one is in work")

endmodule

### design/rbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rbd_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
